[hw/rtl/c32z_pkg.sv]
// c32z_pkg: shared types, constants and GF(2) helpers for the CRC32C
// zero-byte extension block. No dependencies.
// Holds the advance-matrix ROM, which is built at elaboration by repeated squaring.
package c32z_pkg;

    localparam logic [31:0] CRC_POLY = 32'h82F63B78;
    // The low count bits are done one zero byte at a time, the high bits by matrices
    localparam int LOW_BITS = 4;
    localparam int COUNT_WIDTH_DEF = 32;
    localparam int MAX_STEPS = 32 - LOW_BITS;

    typedef logic [31:0] crc_t;
    // Column b is the image of the unit vector at bit b
    typedef logic [31:0][31:0] mat_t;
    typedef mat_t [MAX_STEPS-1:0] rom_t;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load;
        logic step_high;
        logic step_low;
        logic out_load;
    } dp_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic high_zero;
        logic low_zero;
    } dp_status_t;

    // Advance a reflected CRC over one zero byte
    function automatic crc_t one_zero_byte(crc_t c);
        crc_t r;
        r = c;
        for (int i = 0; i < 8; i++)
        begin
            r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
        end
        return r;
    endfunction

    // GF(2) matrix times vector: XOR of the columns picked by the set bits
    function automatic crc_t mat_apply(mat_t m, crc_t v);
        crc_t acc;
        acc = '0;
        for (int b = 0; b < 32; b++)
        begin
            if (v[b])
            begin
                acc = acc ^ m[b];
            end
        end
        return acc;
    endfunction

    function automatic mat_t mat_square(mat_t m);
        mat_t t;
        for (int b = 0; b < 32; b++)
        begin
            t[b] = mat_apply(m, m[b]);
        end
        return t;
    endfunction

    // Entry k advances the CRC by 16 * 2^k zero bytes
    function automatic rom_t gen_rom();
        rom_t rom;
        mat_t m;
        for (int b = 0; b < 32; b++)
        begin
            m[b] = one_zero_byte(crc_t'(1) << b);
        end
        for (int s = 0; s < LOW_BITS; s++)
        begin
            m = mat_square(m);
        end
        for (int k = 0; k < MAX_STEPS; k++)
        begin
            rom[k] = m;
            m = mat_square(m);
        end
        return rom;
    endfunction

    localparam rom_t ADV_ROM = gen_rom();

endpackage

[hw/rtl/c32z_datapath.sv]
// c32z_datapath: CRC register, count registers, matrix step and byte step.
// Depends on c32z_pkg; driven by c32z_ctrl through dp_cmd_t / dp_status_t.
module c32z_datapath
    import c32z_pkg::*;
#(
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
)
(
    input  logic                   clk,
    input  logic [31:0]            crc_in,
    input  logic [COUNT_WIDTH-1:0] zero_count,
    input  dp_cmd_t                cmd,
    output dp_status_t             status,
    output logic [31:0]            crc_out
);

    localparam int HIGH_WIDTH = COUNT_WIDTH - LOW_BITS;
    localparam int KW = (HIGH_WIDTH > 1) ? $clog2(HIGH_WIDTH) : 1;

    crc_t                  crc_reg, crc_next;
    logic [HIGH_WIDTH-1:0] high_reg, high_next;
    logic [KW-1:0]         k_reg, k_next;
    logic [LOW_BITS-1:0]   low_reg, low_next;
    crc_t                  out_reg;

    // Next-value selection for the working registers
    always_comb
    begin
        crc_next  = crc_reg;
        high_next = high_reg;
        k_next    = k_reg;
        low_next  = low_reg;
        if (cmd.load)
        begin
            crc_next  = crc_in;
            high_next = zero_count[COUNT_WIDTH-1:LOW_BITS];
            low_next  = zero_count[LOW_BITS-1:0];
            k_next    = '0;
        end
        else if (cmd.step_high)
        begin
            // one matrix per high count bit, lowest first
            if (high_reg[0])
            begin
                crc_next = mat_apply(ADV_ROM[k_reg], crc_reg);
            end
            high_next = high_reg >> 1;
            k_next    = k_reg + KW'(1);
        end
        else if (cmd.step_low)
        begin
            crc_next = one_zero_byte(crc_reg);
            low_next = low_reg - LOW_BITS'(1);
        end
    end

    // Payload registers, loaded before use so no reset
    always_ff @(posedge clk)
    begin
        crc_reg  <= crc_next;
        high_reg <= high_next;
        k_reg    <= k_next;
        low_reg  <= low_next;
        if (cmd.out_load)
        begin
            out_reg <= crc_reg;
        end
    end

    assign status.high_zero = (high_reg == '0);
    assign status.low_zero  = (low_reg == '0);
    assign crc_out          = out_reg;

endmodule

[hw/rtl/c32z_ctrl.sv]
// c32z_ctrl: sequencing state machine and output valid flag.
// Depends on c32z_pkg; commands c32z_datapath.
module c32z_ctrl
    import c32z_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    output logic       out_valid,
    input  logic       out_stall,
    input  dp_status_t status,
    output dp_cmd_t    cmd
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_HIGH = 2'd1;
    localparam logic [1:0] S_LOW  = 2'd2;
    localparam logic [1:0] S_DONE = 2'd3;

    logic [1:0] state_reg, state_next;
    logic       out_valid_reg, out_valid_next;
    logic       out_free;

    // Output register may be refilled when empty or emptied this cycle
    assign out_free = !out_valid_reg || !out_stall;

    // State transitions and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_HIGH;
                end
            end
            S_HIGH:
            begin
                if (status.high_zero)
                begin
                    state_next = S_LOW;
                end
                else
                begin
                    cmd.step_high = 1'b1;
                end
            end
            S_LOW:
            begin
                if (status.low_zero)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    cmd.step_low = 1'b1;
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Output beat flag
    always_comb
    begin
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;

endmodule

[hw/rtl/crc32c_zero_extend_top.sv]
// Advances a raw reflected CRC32C over a run of zero bytes.
// Input channel: in_valid / in_stall carry one beat of crc_in and zero_count.
// Output channel: out_valid / out_stall carry one beat of crc_out.
// A beat moves on a rising edge with valid high and stall low.
// The count splits into a low part (count mod 16), done one zero byte per
// cycle, and a high part in units of 16 bytes; each high bit up to the top
// set one is handled in turn, a set bit applying a 32x32 GF(2) ROM matrix.
// One item is worked on at a time, so the input stalls until the result sits
// in the output register; how long that takes follows from the matrix steps
// and byte steps that the count needs.
// A held result does not block the next input beat; a finished second
// result waits until the receiver takes the first.
// Reset clears the controller and output valid flag; datapath is not reset.
// Depends on c32z_pkg, c32z_ctrl, c32z_datapath.
module crc32c_zero_extend_top
    import c32z_pkg::*;
#(
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic [31:0]            crc_in,
    input  logic [COUNT_WIDTH-1:0] zero_count,
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic [31:0]            crc_out
);

    dp_cmd_t    cmd;
    dp_status_t status;

    // Sequencer
    c32z_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .cmd       (cmd)
    );

    // CRC datapath
    c32z_datapath #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_datapath
    (
        .clk        (clk),
        .crc_in     (crc_in),
        .zero_count (zero_count),
        .cmd        (cmd),
        .status     (status),
        .crc_out    (crc_out)
    );

`ifndef SYNTHESIS
    // an accepted beat blocks the input while it is worked on
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("input not stalled after accepted beat");

    // one datapath command at a time
    a_cmd_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.load, cmd.step_high, cmd.step_low, cmd.out_load}))
        else $error("more than one datapath command");

    // never overwrite a result the receiver has not taken
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> !(out_valid && out_stall))
        else $error("output register overwritten while stalled");

    // matrix steps only while high count bits remain
    a_high_step: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.step_high |-> !status.high_zero)
        else $error("matrix step with empty high count");
`endif

endmodule
